// ===== rtl/core/md2_pkg.sv =====
// MD2 package: shared sizes, the S permutation, the controller/datapath command
// struct. No dependencies.
`default_nettype none
package md2_pkg;
    localparam int BlockBytes = 16;
    localparam int Rounds     = 18;
    localparam int WorkBytes  = 48;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] idx_t;
    typedef logic [5:0] widx_t;
    typedef logic [4:0] rnd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_byte;   // write one message byte into the block buffer
        logic pad_fill;    // write pad bytes from fill position onward
        logic sel_cksum;   // process the checksum block instead of the buffer
        logic blk_load;    // load the work array from state and block
        logic rnd_step;    // one work-array byte through the round function
        logic blk_done;    // copy result into the hash state
        logic ck_step;     // one checksum byte update
        logic digest_cap;  // not driven by the controller; the digest is read from the hash state
        logic clear;       // clear hash state and checksum
    } md2_cmd_t;

    typedef struct packed {
        logic [3:0] fill;
    } md2_stat_t;

    function automatic byte_t sbox(input byte_t a);
        byte_t s;
        case (a)
            8'd0: s = 8'd41; 8'd1: s = 8'd46; 8'd2: s = 8'd67; 8'd3: s = 8'd201;
            8'd4: s = 8'd162; 8'd5: s = 8'd216; 8'd6: s = 8'd124; 8'd7: s = 8'd1;
            8'd8: s = 8'd61; 8'd9: s = 8'd54; 8'd10: s = 8'd84; 8'd11: s = 8'd161;
            8'd12: s = 8'd236; 8'd13: s = 8'd240; 8'd14: s = 8'd6; 8'd15: s = 8'd19;
            8'd16: s = 8'd98; 8'd17: s = 8'd167; 8'd18: s = 8'd5; 8'd19: s = 8'd243;
            8'd20: s = 8'd192; 8'd21: s = 8'd199; 8'd22: s = 8'd115; 8'd23: s = 8'd140;
            8'd24: s = 8'd152; 8'd25: s = 8'd147; 8'd26: s = 8'd43; 8'd27: s = 8'd217;
            8'd28: s = 8'd188; 8'd29: s = 8'd76; 8'd30: s = 8'd130; 8'd31: s = 8'd202;
            8'd32: s = 8'd30; 8'd33: s = 8'd155; 8'd34: s = 8'd87; 8'd35: s = 8'd60;
            8'd36: s = 8'd253; 8'd37: s = 8'd212; 8'd38: s = 8'd224; 8'd39: s = 8'd22;
            8'd40: s = 8'd103; 8'd41: s = 8'd66; 8'd42: s = 8'd111; 8'd43: s = 8'd24;
            8'd44: s = 8'd138; 8'd45: s = 8'd23; 8'd46: s = 8'd229; 8'd47: s = 8'd18;
            8'd48: s = 8'd190; 8'd49: s = 8'd78; 8'd50: s = 8'd196; 8'd51: s = 8'd214;
            8'd52: s = 8'd218; 8'd53: s = 8'd158; 8'd54: s = 8'd222; 8'd55: s = 8'd73;
            8'd56: s = 8'd160; 8'd57: s = 8'd251; 8'd58: s = 8'd245; 8'd59: s = 8'd142;
            8'd60: s = 8'd187; 8'd61: s = 8'd47; 8'd62: s = 8'd238; 8'd63: s = 8'd122;
            8'd64: s = 8'd169; 8'd65: s = 8'd104; 8'd66: s = 8'd121; 8'd67: s = 8'd145;
            8'd68: s = 8'd21; 8'd69: s = 8'd178; 8'd70: s = 8'd7; 8'd71: s = 8'd63;
            8'd72: s = 8'd148; 8'd73: s = 8'd194; 8'd74: s = 8'd16; 8'd75: s = 8'd137;
            8'd76: s = 8'd11; 8'd77: s = 8'd34; 8'd78: s = 8'd95; 8'd79: s = 8'd33;
            8'd80: s = 8'd128; 8'd81: s = 8'd127; 8'd82: s = 8'd93; 8'd83: s = 8'd154;
            8'd84: s = 8'd90; 8'd85: s = 8'd144; 8'd86: s = 8'd50; 8'd87: s = 8'd39;
            8'd88: s = 8'd53; 8'd89: s = 8'd62; 8'd90: s = 8'd204; 8'd91: s = 8'd231;
            8'd92: s = 8'd191; 8'd93: s = 8'd247; 8'd94: s = 8'd151; 8'd95: s = 8'd3;
            8'd96: s = 8'd255; 8'd97: s = 8'd25; 8'd98: s = 8'd48; 8'd99: s = 8'd179;
            8'd100: s = 8'd72; 8'd101: s = 8'd165; 8'd102: s = 8'd181; 8'd103: s = 8'd209;
            8'd104: s = 8'd215; 8'd105: s = 8'd94; 8'd106: s = 8'd146; 8'd107: s = 8'd42;
            8'd108: s = 8'd172; 8'd109: s = 8'd86; 8'd110: s = 8'd170; 8'd111: s = 8'd198;
            8'd112: s = 8'd79; 8'd113: s = 8'd184; 8'd114: s = 8'd56; 8'd115: s = 8'd210;
            8'd116: s = 8'd150; 8'd117: s = 8'd164; 8'd118: s = 8'd125; 8'd119: s = 8'd182;
            8'd120: s = 8'd118; 8'd121: s = 8'd252; 8'd122: s = 8'd107; 8'd123: s = 8'd226;
            8'd124: s = 8'd156; 8'd125: s = 8'd116; 8'd126: s = 8'd4; 8'd127: s = 8'd241;
            8'd128: s = 8'd69; 8'd129: s = 8'd157; 8'd130: s = 8'd112; 8'd131: s = 8'd89;
            8'd132: s = 8'd100; 8'd133: s = 8'd113; 8'd134: s = 8'd135; 8'd135: s = 8'd32;
            8'd136: s = 8'd134; 8'd137: s = 8'd91; 8'd138: s = 8'd207; 8'd139: s = 8'd101;
            8'd140: s = 8'd230; 8'd141: s = 8'd45; 8'd142: s = 8'd168; 8'd143: s = 8'd2;
            8'd144: s = 8'd27; 8'd145: s = 8'd96; 8'd146: s = 8'd37; 8'd147: s = 8'd173;
            8'd148: s = 8'd174; 8'd149: s = 8'd176; 8'd150: s = 8'd185; 8'd151: s = 8'd246;
            8'd152: s = 8'd28; 8'd153: s = 8'd70; 8'd154: s = 8'd97; 8'd155: s = 8'd105;
            8'd156: s = 8'd52; 8'd157: s = 8'd64; 8'd158: s = 8'd126; 8'd159: s = 8'd15;
            8'd160: s = 8'd85; 8'd161: s = 8'd71; 8'd162: s = 8'd163; 8'd163: s = 8'd35;
            8'd164: s = 8'd221; 8'd165: s = 8'd81; 8'd166: s = 8'd175; 8'd167: s = 8'd58;
            8'd168: s = 8'd195; 8'd169: s = 8'd92; 8'd170: s = 8'd249; 8'd171: s = 8'd206;
            8'd172: s = 8'd186; 8'd173: s = 8'd197; 8'd174: s = 8'd234; 8'd175: s = 8'd38;
            8'd176: s = 8'd44; 8'd177: s = 8'd83; 8'd178: s = 8'd13; 8'd179: s = 8'd110;
            8'd180: s = 8'd133; 8'd181: s = 8'd40; 8'd182: s = 8'd132; 8'd183: s = 8'd9;
            8'd184: s = 8'd211; 8'd185: s = 8'd223; 8'd186: s = 8'd205; 8'd187: s = 8'd244;
            8'd188: s = 8'd65; 8'd189: s = 8'd129; 8'd190: s = 8'd77; 8'd191: s = 8'd82;
            8'd192: s = 8'd106; 8'd193: s = 8'd220; 8'd194: s = 8'd55; 8'd195: s = 8'd200;
            8'd196: s = 8'd108; 8'd197: s = 8'd193; 8'd198: s = 8'd171; 8'd199: s = 8'd250;
            8'd200: s = 8'd36; 8'd201: s = 8'd225; 8'd202: s = 8'd123; 8'd203: s = 8'd8;
            8'd204: s = 8'd12; 8'd205: s = 8'd189; 8'd206: s = 8'd177; 8'd207: s = 8'd74;
            8'd208: s = 8'd120; 8'd209: s = 8'd136; 8'd210: s = 8'd149; 8'd211: s = 8'd139;
            8'd212: s = 8'd227; 8'd213: s = 8'd99; 8'd214: s = 8'd232; 8'd215: s = 8'd109;
            8'd216: s = 8'd233; 8'd217: s = 8'd203; 8'd218: s = 8'd213; 8'd219: s = 8'd254;
            8'd220: s = 8'd59; 8'd221: s = 8'd0; 8'd222: s = 8'd29; 8'd223: s = 8'd57;
            8'd224: s = 8'd242; 8'd225: s = 8'd239; 8'd226: s = 8'd183; 8'd227: s = 8'd14;
            8'd228: s = 8'd102; 8'd229: s = 8'd88; 8'd230: s = 8'd208; 8'd231: s = 8'd228;
            8'd232: s = 8'd166; 8'd233: s = 8'd119; 8'd234: s = 8'd114; 8'd235: s = 8'd248;
            8'd236: s = 8'd235; 8'd237: s = 8'd117; 8'd238: s = 8'd75; 8'd239: s = 8'd10;
            8'd240: s = 8'd49; 8'd241: s = 8'd68; 8'd242: s = 8'd80; 8'd243: s = 8'd180;
            8'd244: s = 8'd143; 8'd245: s = 8'd237; 8'd246: s = 8'd31; 8'd247: s = 8'd26;
            8'd248: s = 8'd219; 8'd249: s = 8'd153; 8'd250: s = 8'd141; 8'd251: s = 8'd51;
            8'd252: s = 8'd159; 8'd253: s = 8'd17; 8'd254: s = 8'd131; 8'd255: s = 8'd20;
            default: s = 8'd0;
        endcase
        return s;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/md2_if.sv =====
// Valid/ready channel interfaces for the MD2 core.
// Depends on nothing.
`default_nettype none
interface md2_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
    modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface md2_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_high;
    logic [63:0] digest_low;
    modport source (output valid, digest_high, digest_low, input ready);
    modport sink   (input valid, digest_high, digest_low, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/md2_datapath.sv =====
// MD2 datapath: block buffer, hash state, checksum, 48-byte work register and
// the byte-serial round unit. Depends on md2_pkg.
`default_nettype none
module md2_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire md2_pkg::md2_cmd_t cmd,
    input  wire md2_pkg::idx_t    idx,      // byte index for buffer/checksum ops
    input  wire md2_pkg::widx_t   widx,     // work-array position
    input  wire md2_pkg::rnd_t    rnd,      // current round
    input  wire logic [7:0]       in_byte,
    input  wire logic [3:0]       fill,
    output logic [127:0]          digest
);
    md2_pkg::byte_t buf_reg  [md2_pkg::BlockBytes];
    md2_pkg::byte_t hs_reg   [md2_pkg::BlockBytes];
    md2_pkg::byte_t ck_reg   [md2_pkg::BlockBytes];
    md2_pkg::byte_t blk_reg  [md2_pkg::BlockBytes];  // snapshot of the block in flight
    md2_pkg::byte_t work_reg [md2_pkg::WorkBytes];
    md2_pkg::byte_t t_reg;
    md2_pkg::byte_t ct_reg;
    md2_pkg::byte_t wnew;
    md2_pkg::byte_t cnew;
    md2_pkg::byte_t padv;

    assign padv = 8'(5'd16 - {1'b0, fill});
    assign wnew = work_reg[0] ^ md2_pkg::sbox(t_reg);
    assign cnew = ck_reg[idx] ^ md2_pkg::sbox(blk_reg[idx] ^ ct_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
        begin
            buf_reg[idx] <= in_byte;
        end
        if (cmd.pad_fill)
        begin
            for (int i = 0; i < md2_pkg::BlockBytes; i++)
            begin
                if (4'(i) >= fill)
                begin
                    buf_reg[i] <= padv;
                end
            end
        end
        if (cmd.blk_load)
        begin
            for (int i = 0; i < md2_pkg::BlockBytes; i++)
            begin
                blk_reg[i]       <= cmd.sel_cksum ? ck_reg[i] : buf_reg[i];
                work_reg[i]      <= hs_reg[i];
                work_reg[i + 16] <= cmd.sel_cksum ? ck_reg[i] : buf_reg[i];
                work_reg[i + 32] <= hs_reg[i] ^ (cmd.sel_cksum ? ck_reg[i] : buf_reg[i]);
            end
            t_reg  <= '0;
            ct_reg <= ck_reg[md2_pkg::BlockBytes - 1];
        end
        if (cmd.rnd_step)
        begin
            // rotate: the head byte goes through the round and re-enters at the tail
            for (int i = 0; i < md2_pkg::WorkBytes - 1; i++)
            begin
                work_reg[i] <= work_reg[i + 1];
            end
            work_reg[md2_pkg::WorkBytes - 1] <= wnew;
            // close a round: add the round number into the chain byte
            t_reg <= (widx == 6'(md2_pkg::WorkBytes - 1)) ? wnew + 8'(rnd) : wnew;
        end
        if (cmd.ck_step)
        begin
            ct_reg <= cnew;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < md2_pkg::BlockBytes; i++)
            begin
                hs_reg[i] <= '0;
                ck_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < md2_pkg::BlockBytes; i++)
            begin
                hs_reg[i] <= '0;
                ck_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.blk_done)
            begin
                for (int i = 0; i < md2_pkg::BlockBytes; i++)
                begin
                    hs_reg[i] <= work_reg[i];
                end
            end
            if (cmd.ck_step)
            begin
                ck_reg[idx] <= cnew;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < md2_pkg::BlockBytes; i++)
        begin
            digest[127 - 8*i -: 8] = hs_reg[i];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/md2_ctrl.sv =====
// MD2 controller: accepts beats, sequences block processing and the final
// padding/checksum blocks, drives the output handshake. Depends on md2_pkg.
`default_nettype none
module md2_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              byte_present,
    input  wire logic              end_of_message,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output md2_pkg::md2_cmd_t      cmd,
    output md2_pkg::idx_t          idx,
    output md2_pkg::widx_t         widx,
    output md2_pkg::rnd_t          rnd,
    output md2_pkg::md2_stat_t     stat
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_RND   = 6'b000100,
        S_CK    = 6'b001000,
        S_DONE  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    // phase of the message: normal data block, padded block, checksum block
    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_PAD  = 2'd1,
        PH_CK   = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [3:0] fill_reg, fill_next;
    md2_pkg::widx_t widx_reg, widx_next;
    md2_pkg::rnd_t  rnd_reg, rnd_next;
    md2_pkg::idx_t  ci_reg, ci_next;
    logic end_reg, end_next;
    // final_reg marks that the block in flight is the padded block
    logic final_reg, final_next;
    logic accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign accept    = in_valid && in_ready;
    assign stat.fill = fill_reg;
    assign widx = widx_reg;
    assign rnd  = rnd_reg;
    assign idx  = (state_reg == S_CK) ? ci_reg : fill_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        fill_next  = fill_reg;
        widx_next  = widx_reg;
        rnd_next   = rnd_reg;
        ci_next    = ci_reg;
        end_next   = end_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    end_next = end_of_message;
                    if (byte_present)
                    begin
                        cmd.load_byte = 1'b1;
                        fill_next = fill_reg + 4'd1;
                    end
                    if (byte_present && fill_reg == 4'd15)
                    begin
                        phase_next = PH_DATA;
                        state_next = S_LOAD;
                    end
                    else if (end_of_message)
                    begin
                        phase_next = PH_PAD;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                if (phase_reg == PH_PAD)
                begin
                    // pad in place first, then load next cycle
                    cmd.pad_fill = 1'b1;
                    phase_next = PH_DATA;
                    end_next   = 1'b0;
                    // reuse: mark padded block as final data block
                end
                else
                begin
                    cmd.blk_load  = 1'b1;
                    cmd.sel_cksum = (phase_reg == PH_CK);
                    fill_next = '0;
                    widx_next = '0;
                    rnd_next  = '0;
                    ci_next   = '0;
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                cmd.rnd_step = 1'b1;
                widx_next = widx_reg + 6'd1;
                if (widx_reg == 6'(md2_pkg::WorkBytes - 1))
                begin
                    widx_next = '0;
                    rnd_next  = rnd_reg + 5'd1;
                    if (rnd_reg == 5'(md2_pkg::Rounds - 1))
                    begin
                        state_next = S_CK;
                    end
                end
            end
            S_CK:
            begin
                // the checksum block itself leaves the checksum alone
                cmd.ck_step = (phase_reg != PH_CK);
                ci_next = ci_reg + 4'd1;
                if (ci_reg == 4'd15 || phase_reg == PH_CK)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.blk_done = 1'b1;
                if (phase_reg == PH_CK)
                begin
                    state_next = S_OUT;
                end
                else if (final_reg)
                begin
                    phase_next = PH_CK;
                    state_next = S_LOAD;
                end
                else if (end_reg)
                begin
                    phase_next = PH_PAD;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.clear  = 1'b1;
                    phase_next = PH_DATA;
                    fill_next  = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        final_next = final_reg;
        if (state_reg == S_LOAD && phase_reg == PH_PAD)
        begin
            final_next = 1'b1;
        end
        else if (state_reg == S_DONE && final_reg)
        begin
            final_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DATA;
            fill_reg  <= '0;
            widx_reg  <= '0;
            rnd_reg   <= '0;
            ci_reg    <= '0;
            end_reg   <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            widx_reg  <= widx_next;
            rnd_reg   <= rnd_next;
            ci_reg    <= ci_next;
            end_reg   <= end_next;
            final_reg <= final_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input open while digest pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_ready) |=> state_reg == S_OUT)
        else $error("digest dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RND) |-> rnd_reg < 5'(md2_pkg::Rounds))
        else $error("round counter overran");
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> fill_reg == 4'd0)
        else $error("fill not cleared after digest");
endmodule
`default_nettype wire

// ===== rtl/core/md2_message_digest_core.sv =====
// MD2 digest core top level: controller plus datapath, valid/ready channels.
// Depends on md2_pkg, md2_if, md2_ctrl, md2_datapath.
//
// A beat carrying a byte that does not complete a block leaves the core idle
// and ready for the next beat. A completed block occupies the core for a load
// step, the round unit (18 rounds of 48 work-array bytes, one byte per cycle),
// a checksum pass over the 16 block bytes and a write-back step. End of message
// adds a pad step, the padded block and then the checksum block, whose checksum
// stage leaves the checksum alone, before the digest is offered, plus the data
// block if the last byte filled one. The digest is held until taken; input is
// not accepted meanwhile.
`default_nettype none
module md2_message_digest_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    md2_in_if.sink     in_ch,
    md2_out_if.source  out_ch
);
    md2_pkg::md2_cmd_t  cmd;
    md2_pkg::md2_stat_t stat;
    md2_pkg::idx_t      idx;
    md2_pkg::widx_t     widx;
    md2_pkg::rnd_t      rnd;
    logic [127:0]       digest;

    md2_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .byte_present   (in_ch.byte_present),
        .end_of_message (in_ch.end_of_message),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .cmd            (cmd),
        .idx            (idx),
        .widx           (widx),
        .rnd            (rnd),
        .stat           (stat)
    );

    md2_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .idx     (idx),
        .widx    (widx),
        .rnd     (rnd),
        .in_byte (in_ch.msg_byte),
        .fill    (stat.fill),
        .digest  (digest)
    );

    assign out_ch.digest_high = digest[127:64];
    assign out_ch.digest_low  = digest[63:0];
endmodule
`default_nettype wire
